/* hw/rtl/bsc_pkg.sv */
// ============================================================================
// bsc_pkg: boiler supervisory controller package
// Types, codes, fixed thresholds and angle helpers shared by the block.
// ============================================================================
package bsc_pkg;

  typedef logic signed [15:0] temp_t;

  // Item opcodes
  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_SERVO    = 2'd1,
    OP_IGNITION = 2'd2,
    OP_FAN      = 2'd3
  } op_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_CPUMP_ON    = 3'd0,
    CFG_CPUMP_OFF   = 3'd1,
    CFG_FEED_ON     = 3'd2,
    CFG_FEED_OFF    = 3'd3,
    CFG_OVERHEAT_ON = 3'd4,
    CFG_OVERHEAT_OFF= 3'd5,
    CFG_FAN_ON_BELOW= 3'd6,
    CFG_FAN_OFF_ABOVE=3'd7
  } cfg_idx_e;

  localparam int unsigned CfgIdxW   = 4;
  localparam int unsigned NumServos = 3;
  localparam logic [31:0] ServoPowerMs = 32'd5000;

  // Fixed activity thresholds (1/16 degree)
  localparam temp_t ActiveOutletOn  = 16'sd1520;
  localparam temp_t ActiveFlueOn    = 16'sd1744;
  localparam temp_t ActiveOutletOff = 16'sd1504;
  localparam temp_t ActiveFlueOff   = 16'sd1728;
  localparam temp_t AccumWarmOn     = 16'sd448;
  localparam temp_t AccumWarmOff    = 16'sd432;

  localparam logic [6:0] PctMax = 7'd100;

  // Relay bit positions
  localparam int unsigned RlyBpump  = 0;
  localparam int unsigned RlyCpump  = 1;
  localparam int unsigned RlyValve  = 2;
  localparam int unsigned RlyFan    = 3;
  localparam int unsigned RlyDamper = 4;
  localparam int unsigned RlyPower  = 5;

  localparam logic [5:0] RelayReset = 6'd53;

  typedef struct packed {
    temp_t cpump_on;
    temp_t cpump_off;
    temp_t feed_on;
    temp_t feed_off;
    temp_t overheat_on;
    temp_t overheat_off;
    temp_t fan_on_below;
    temp_t fan_off_above;
  } cfg_t;

  typedef struct packed {
    logic active;
    logic overheat;
    logic ignition;
    logic chot;
    logic feed;
    logic prev;
    logic awarm;
    logic fanok;
  } flags_t;

  typedef struct packed {
    logic [5:0]                    relay;
    logic [NumServos-1:0][6:0]     pos;
    logic [NumServos-1:0][6:0]     saved;
    logic [31:0]                   power_start;
    flags_t                        flags;
  } state_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] now_ms;
    temp_t       outlet_temp;
    temp_t       accum_top_temp;
    temp_t       flue_temp;
    logic [1:0]  servo_select;
    logic [7:0]  command_value;
  } in_item_t;

  typedef struct packed {
    logic [5:0] relay_bits;
    logic [6:0] servo1_pct;
    logic [6:0] servo2_pct;
    logic [6:0] servo3_pct;
    logic [7:0] servo1_angle;
    logic [6:0] servo2_angle;
    logic [6:0] servo3_angle;
    logic       overheat;
    logic       ignition_on;
    logic       boiler_active;
    logic       accepted;
  } res_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [15:0]        data;
  } cfg_wr_t;

  // floor(x/10) for x < 2048 via reciprocal 6554/2^16
  function automatic logic [10:0] div10(input logic [10:0] x);
    logic [23:0] prod;
    prod = 24'(x) * 24'd6554;
    return {3'b000, prod[23:16]};
  endfunction

  // floor((100-p)*17/10)
  function automatic logic [7:0] angle17(input logic [6:0] pct);
    logic [10:0] d;
    logic [10:0] q;
    d = 11'(PctMax - pct) * 11'd17;
    q = div10(d);
    return q[7:0];
  endfunction

  // floor((100-p)*9/10)
  function automatic logic [6:0] angle9(input logic [6:0] pct);
    logic [10:0] d;
    logic [10:0] q;
    d = 11'(PctMax - pct) * 11'd9;
    q = div10(d);
    return q[6:0];
  endfunction

endpackage

/* hw/rtl/bsc_intf.sv */
// ============================================================================
// bsc_intf: channel interfaces
// Valid/ready channels for items, results and configuration writes.
// ============================================================================
interface bsc_in_if;
  logic               valid;
  logic               ready;
  bsc_pkg::in_item_t  item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface bsc_out_if;
  logic           valid;
  logic           ready;
  bsc_pkg::res_t  item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface bsc_cfg_if;
  logic              valid;
  logic              ready;
  bsc_pkg::cfg_wr_t  item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

/* hw/rtl/boiler_supervisory_controller.sv */
// ============================================================================
// boiler_supervisory_controller: solid-fuel boiler supervisor
// Control ticks and commands in, relay/servo/status snapshot out.
// ============================================================================
// Each input transaction (a control tick, a servo write, an ignition request
// or a smoke fan request) produces exactly one result transaction holding the
// relay bits, the three servo positions and drive angles and the status flags
// as they stand after that item. Rate: one item per clock while out_o.ready
// stays high. An item is captured in an input register; once the result
// register is free or draining, bsc_step runs the whole state update in one
// combinational pass that lands in the state and result registers together.
// The result register decouples a stalled consumer, so a new item is still
// taken into an empty input register while a result waits. Configuration
// writes (eight signed 16-bit thresholds, index 0..7; higher indexes are
// ignored) are always ready and should only be issued while the block is idle.
// ============================================================================
module boiler_supervisory_controller #(
  parameter logic [31:0]    ServoPowerMs = bsc_pkg::ServoPowerMs,
  parameter bsc_pkg::temp_t AccumWarmOn  = bsc_pkg::AccumWarmOn,
  parameter bsc_pkg::temp_t AccumWarmOff = bsc_pkg::AccumWarmOff
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bsc_in_if.sink    in_i,
  bsc_cfg_if.sink   cfg_i,
  bsc_out_if.source out_o
);

  // Input register
  logic              s1_valid_q, s1_valid_d;
  bsc_pkg::in_item_t s1_item_q;

  // Result register
  logic              out_valid_q, out_valid_d;
  bsc_pkg::res_t     res_q;
  bsc_pkg::res_t     res_d;

  // Controller state and thresholds
  bsc_pkg::state_t   st_q, st_d;
  bsc_pkg::cfg_t     regs_q;

  logic in_fire;
  logic adv;      // input stage moves into the result register

  assign adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || adv;
  assign in_fire = in_i.valid && in_i.ready;

  assign cfg_i.ready = 1'b1;

  bsc_step #(
    .ServoPowerMs (ServoPowerMs),
    .AccumWarmOn  (AccumWarmOn),
    .AccumWarmOff (AccumWarmOff)
  ) u_step (
    .st_i   (st_q),
    .regs_i (regs_q),
    .item_i (s1_item_q),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= in_i.item;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  // State updates only when an item completes its pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.relay       <= bsc_pkg::RelayReset;
      st_q.pos         <= '0;
      st_q.saved       <= '0;
      st_q.power_start <= '0;
      st_q.flags       <= '0;
    end else if (adv) begin
      st_q <= st_d;
    end
  end

  // Threshold registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.cpump_on      <= 16'sd1040;
      regs_q.cpump_off     <= 16'sd960;
      regs_q.feed_on       <= 16'sd1360;
      regs_q.feed_off      <= 16'sd1344;
      regs_q.overheat_on   <= 16'sd1536;
      regs_q.overheat_off  <= 16'sd1520;
      regs_q.fan_on_below  <= 16'sd1824;
      regs_q.fan_off_above <= 16'sd2160;
    end else if (cfg_i.valid && !cfg_i.item.index[bsc_pkg::CfgIdxW-1]) begin
      unique case (bsc_pkg::cfg_idx_e'(cfg_i.item.index[2:0]))
        bsc_pkg::CFG_CPUMP_ON:      regs_q.cpump_on      <= cfg_i.item.data;
        bsc_pkg::CFG_CPUMP_OFF:     regs_q.cpump_off     <= cfg_i.item.data;
        bsc_pkg::CFG_FEED_ON:       regs_q.feed_on       <= cfg_i.item.data;
        bsc_pkg::CFG_FEED_OFF:      regs_q.feed_off      <= cfg_i.item.data;
        bsc_pkg::CFG_OVERHEAT_ON:   regs_q.overheat_on   <= cfg_i.item.data;
        bsc_pkg::CFG_OVERHEAT_OFF:  regs_q.overheat_off  <= cfg_i.item.data;
        bsc_pkg::CFG_FAN_ON_BELOW:  regs_q.fan_on_below  <= cfg_i.item.data;
        bsc_pkg::CFG_FAN_OFF_ABOVE: regs_q.fan_off_above <= cfg_i.item.data;
        default: ;
      endcase
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.item  = res_q;

endmodule

/* hw/rtl/bsc_step.sv */
// ============================================================================
// bsc_step: one-item state update
// Next state and result for one item, given the current state and registers.
// ============================================================================
module bsc_step #(
  parameter logic [31:0]    ServoPowerMs = bsc_pkg::ServoPowerMs,
  parameter bsc_pkg::temp_t AccumWarmOn  = bsc_pkg::AccumWarmOn,
  parameter bsc_pkg::temp_t AccumWarmOff = bsc_pkg::AccumWarmOff
) (
  input  bsc_pkg::state_t   st_i,
  input  bsc_pkg::cfg_t     regs_i,
  input  bsc_pkg::in_item_t item_i,
  output bsc_pkg::state_t   st_o,
  output bsc_pkg::res_t     res_o
);

  bsc_pkg::state_t nx;
  logic            acc_ok;
  logic            flag;
  logic [6:0]      clip_pct;
  logic [31:0]     power_lim;

  assign flag      = item_i.command_value[0];
  assign clip_pct  = (item_i.command_value > 8'(bsc_pkg::PctMax)) ?
                     bsc_pkg::PctMax : item_i.command_value[6:0];
  assign power_lim = st_i.power_start + ServoPowerMs;

  always_comb begin
    nx     = st_i;
    acc_ok = 1'b1;
    unique case (bsc_pkg::op_e'(item_i.op))
      bsc_pkg::OP_TICK: begin
        nx.flags.fanok = 1'b0;
        if (st_i.relay[bsc_pkg::RlyPower]) begin
          if (st_i.power_start > item_i.now_ms) begin
            nx.power_start = item_i.now_ms;
          end else if (item_i.now_ms > power_lim) begin
            nx.relay[bsc_pkg::RlyPower] = 1'b0;
          end
        end
        if (item_i.outlet_temp > bsc_pkg::ActiveOutletOn ||
            item_i.flue_temp > bsc_pkg::ActiveFlueOn) begin
          nx.flags.active = 1'b1;
        end
        if (item_i.outlet_temp < bsc_pkg::ActiveOutletOff &&
            item_i.flue_temp < bsc_pkg::ActiveFlueOff) begin
          nx.flags.active = 1'b0;
        end

        if (nx.flags.active || st_i.flags.ignition) begin
          nx.relay[bsc_pkg::RlyBpump] = 1'b1;
          if (item_i.outlet_temp > regs_i.cpump_on) nx.flags.chot = 1'b1;
          else if (item_i.outlet_temp < regs_i.cpump_off) nx.flags.chot = 1'b0;
          nx.relay[bsc_pkg::RlyCpump] = nx.flags.chot;
          if (item_i.outlet_temp > regs_i.feed_on) nx.flags.feed = 1'b1;
          else if (item_i.outlet_temp < regs_i.feed_off) nx.flags.feed = 1'b0;
          nx.relay[bsc_pkg::RlyValve] = nx.flags.feed;
          if (item_i.outlet_temp > regs_i.overheat_on) nx.flags.overheat = 1'b1;
          else if (item_i.outlet_temp < regs_i.overheat_off) nx.flags.overheat = 1'b0;

          if (nx.flags.overheat) begin
            nx.flags.ignition            = 1'b0;
            nx.relay[bsc_pkg::RlyDamper] = 1'b1;
            nx.relay[bsc_pkg::RlyFan]    = 1'b0;
            if (!st_i.flags.prev) begin
              // entering overheat: park servos, remember where they were
              nx.saved                    = st_i.pos;
              nx.pos                      = '0;
              nx.relay[bsc_pkg::RlyPower] = 1'b1;
              nx.power_start              = item_i.now_ms;
            end
          end else begin
            nx.flags.fanok = 1'b1;
            if (item_i.flue_temp < regs_i.fan_on_below) begin
              nx.relay[bsc_pkg::RlyFan] = 1'b1;
            end else if (item_i.flue_temp > regs_i.fan_off_above) begin
              nx.flags.ignition         = 1'b0;
              nx.relay[bsc_pkg::RlyFan] = 1'b0;
            end
            nx.relay[bsc_pkg::RlyDamper] = nx.relay[bsc_pkg::RlyFan];
            if (st_i.flags.prev) begin
              // leaving overheat: restore positions
              nx.pos                      = st_i.saved;
              nx.relay[bsc_pkg::RlyPower] = 1'b1;
              nx.power_start              = item_i.now_ms;
            end
          end
          nx.flags.prev = nx.flags.overheat;
        end else begin
          nx.relay[bsc_pkg::RlyBpump]  = 1'b0;
          nx.relay[bsc_pkg::RlyDamper] = 1'b1;
          nx.relay[bsc_pkg::RlyFan]    = 1'b0;
          if (item_i.accum_top_temp > AccumWarmOn) nx.flags.awarm = 1'b1;
          else if (item_i.accum_top_temp < AccumWarmOff) nx.flags.awarm = 1'b0;
          nx.relay[bsc_pkg::RlyValve] = nx.flags.awarm;
          nx.relay[bsc_pkg::RlyCpump] = nx.flags.awarm;
        end
      end

      bsc_pkg::OP_SERVO: begin
        if (st_i.flags.overheat || item_i.servo_select == 2'd3) begin
          acc_ok = 1'b0;
        end else begin
          unique case (item_i.servo_select)
            2'd0:    nx.pos[0] = clip_pct;
            2'd1:    nx.pos[1] = clip_pct;
            default: nx.pos[2] = clip_pct;
          endcase
          nx.relay[bsc_pkg::RlyPower] = 1'b1;
          nx.power_start              = item_i.now_ms;
        end
      end

      bsc_pkg::OP_IGNITION: begin
        if (item_i.flue_temp > regs_i.fan_off_above ||
            item_i.outlet_temp > regs_i.overheat_on) begin
          acc_ok = 1'b0;
        end else begin
          nx.flags.ignition = flag;
        end
      end

      bsc_pkg::OP_FAN: begin
        if (!st_i.flags.fanok) begin
          acc_ok = 1'b0;
        end else begin
          nx.relay[bsc_pkg::RlyFan] = flag;
        end
      end

      default: acc_ok = 1'b0;
    endcase
  end

  assign st_o = nx;

  always_comb begin
    res_o.relay_bits    = nx.relay;
    res_o.servo1_pct    = nx.pos[0];
    res_o.servo2_pct    = nx.pos[1];
    res_o.servo3_pct    = nx.pos[2];
    res_o.servo1_angle  = bsc_pkg::angle17(nx.pos[0]);
    res_o.servo2_angle  = bsc_pkg::PctMax - nx.pos[1];
    res_o.servo3_angle  = bsc_pkg::angle9(nx.pos[2]);
    res_o.overheat      = nx.flags.overheat;
    res_o.ignition_on   = nx.flags.ignition;
    res_o.boiler_active = nx.flags.active;
    res_o.accepted      = acc_ok;
  end

endmodule
